// File: hw/rtl/tbsb_pkg.sv
// ---------------------------------------------------------------------------
// tbsb_pkg
// shared widths, codes and types for the torus brush blend pipeline
// ---------------------------------------------------------------------------
`default_nettype none
package tbsb_pkg;

    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned DIFF_W    = 33;   // magnitude of a coordinate difference
    localparam int unsigned RAD_W     = 68;   // radicand of either root
    localparam int unsigned ROOT_W    = 36;   // root result width
    localparam int unsigned DIV_Q_W   = 17;   // blend ratio, q1.16, up to 1.0
    localparam int unsigned DIV_R_W   = 48;   // division remainder width
    localparam int unsigned FRAC_W    = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X = 4'd0,
        REG_CENTER_Y = 4'd1,
        REG_CENTER_Z = 4'd2,
        REG_MAJOR    = 4'd3,
        REG_MINOR    = 4'd4,
        REG_FALLOFF  = 4'd5,
        REG_AIR      = 4'd6,
        REG_SOLID    = 4'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        CLS_OUT  = 2'd0,
        CLS_IN   = 2'd1,
        CLS_BAND = 2'd2
    } cls_t;

    // per-item flags that ride alongside the divider
    typedef struct packed {
        cls_t cls;
        logic dig;
        logic below;
    } blend_ctl_t;

endpackage
`default_nettype wire

// File: hw/rtl/tbsb_if.sv
// ---------------------------------------------------------------------------
// tbsb channel interfaces
// voxel input, blend result and register write channels
// ---------------------------------------------------------------------------
`default_nettype none
interface tbsb_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] terrain_height;
    logic               dig;
    modport source (output valid, pos_x, pos_y, pos_z, terrain_height, dig, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, terrain_height, dig, output ready);
endinterface

interface tbsb_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sdf_value;
    modport source (output valid, sdf_value, input ready);
    modport sink   (input valid, sdf_value, output ready);
endinterface

interface tbsb_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/tbsb_sqrt.sv
// ---------------------------------------------------------------------------
// tbsb_sqrt
// pipelined floor square root, one result bit per stage
// ---------------------------------------------------------------------------
`default_nettype none
module tbsb_sqrt #(
    parameter int unsigned RW = 68,
    parameter int unsigned QW = 36,
    parameter int unsigned SW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [RW-1:0] in_rad,
    input  wire logic [SW-1:0] in_side,
    output logic               out_valid,
    output logic [QW-1:0]      out_root,
    output logic [SW-1:0]      out_side
);
    localparam int unsigned TW = 2*QW + 2;

    logic          v_reg    [QW];
    logic [RW-1:0] rem_reg  [QW];
    logic [QW-1:0] res_reg  [QW];
    logic [SW-1:0] side_reg [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        localparam int unsigned B = QW - 1 - i;
        logic          v_cur;
        logic [RW-1:0] rem_cur;
        logic [QW-1:0] res_cur;
        logic [SW-1:0] side_cur;
        logic [TW-1:0] trial;
        logic [TW-1:0] rem_ext;
        logic          take;

        if (i == 0) begin : g_first
            assign v_cur    = in_valid;
            assign rem_cur  = in_rad;
            assign res_cur  = '0;
            assign side_cur = in_side;
        end else begin : g_next
            assign v_cur    = v_reg[i-1];
            assign rem_cur  = rem_reg[i-1];
            assign res_cur  = res_reg[i-1];
            assign side_cur = side_reg[i-1];
        end

        // (res + 2^b)^2 - res^2
        assign trial   = (TW'(res_cur) << (B + 1)) + (TW'(1) << (2 * B));
        assign rem_ext = TW'(rem_cur);
        assign take    = trial <= rem_ext;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= take ? RW'(rem_ext - trial) : rem_cur;
                res_reg[i]  <= take ? (res_cur | (QW'(1) << B)) : res_cur;
                side_reg[i] <= side_cur;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_root  = res_reg[QW-1];
    assign out_side  = side_reg[QW-1];
endmodule
`default_nettype wire

// File: hw/rtl/tbsb_div.sv
// ---------------------------------------------------------------------------
// tbsb_div
// pipelined restoring divider for the falloff ratio, one quotient bit per stage
// ---------------------------------------------------------------------------
`default_nettype none
module tbsb_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [30:0]                   in_num,
    input  wire logic [30:0]                   divisor,
    input  wire tbsb_pkg::blend_ctl_t          in_ctl,
    output logic                               out_valid,
    output logic [tbsb_pkg::DIV_Q_W-1:0]       out_quo,
    output tbsb_pkg::blend_ctl_t               out_ctl
);
    import tbsb_pkg::*;

    logic               v_reg   [DIV_Q_W];
    logic [DIV_R_W-1:0] rem_reg [DIV_Q_W];
    logic [DIV_Q_W-1:0] q_reg   [DIV_Q_W];
    blend_ctl_t         ctl_reg [DIV_Q_W];

    for (genvar i = 0; i < DIV_Q_W; i++) begin : g_stage
        localparam int unsigned K = DIV_Q_W - 1 - i;
        logic               v_cur;
        logic [DIV_R_W-1:0] rem_cur;
        logic [DIV_Q_W-1:0] q_cur;
        blend_ctl_t         ctl_cur;
        logic [DIV_R_W-1:0] dsh;
        logic               take;

        if (i == 0) begin : g_first
            assign v_cur   = in_valid;
            assign rem_cur = DIV_R_W'({in_num, {FRAC_W{1'b0}}});
            assign q_cur   = '0;
            assign ctl_cur = in_ctl;
        end else begin : g_next
            assign v_cur   = v_reg[i-1];
            assign rem_cur = rem_reg[i-1];
            assign q_cur   = q_reg[i-1];
            assign ctl_cur = ctl_reg[i-1];
        end

        assign dsh  = DIV_R_W'(divisor) << K;
        assign take = rem_cur >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= take ? (rem_cur - dsh) : rem_cur;
                q_reg[i]   <= take ? (q_cur | (DIV_Q_W'(1) << K)) : q_cur;
                ctl_reg[i] <= ctl_cur;
            end
        end
    end

    assign out_valid = v_reg[DIV_Q_W-1];
    assign out_quo   = q_reg[DIV_Q_W-1];
    assign out_ctl   = ctl_reg[DIV_Q_W-1];
endmodule
`default_nettype wire

// File: hw/rtl/torus_brush_sdf_blend.sv
// ---------------------------------------------------------------------------
// torus_brush_sdf_blend
// torus signed distance with smoothstep falloff blend, fully pipelined
// ---------------------------------------------------------------------------
// Takes one voxel beat per cycle while not stalled and returns one sdf_value
// beat per voxel, in order. The pipeline is 101 register stages deep: six of
// difference/square/sum (three before each root), two 36-stage square root
// pipelines (one result bit per stage), one stage of band classification, a
// 17-stage divider for d / falloff, and five stages of smoothstep and lerp
// ending in the output register. The whole pipeline advances together
// whenever the output register is empty or being taken, so sustained
// throughput is one voxel per clock. Registers are written through the cfg
// channel (always ready) and must only change while the pipeline is empty.
// ---------------------------------------------------------------------------
`default_nettype none
module torus_brush_sdf_blend (
    input  wire logic clk,
    input  wire logic rst_n,
    tbsb_in_if.sink   in_ch,
    tbsb_out_if.source out_ch,
    tbsb_cfg_if.sink  cfg
);
    import tbsb_pkg::*;

    // configuration
    logic signed [31:0] center_x_reg, center_y_reg, center_z_reg;
    logic [30:0]        major_reg, minor_reg, falloff_reg;
    logic signed [31:0] air_reg, solid_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            major_reg    <= '0;
            minor_reg    <= '0;
            falloff_reg  <= '0;
            air_reg      <= '0;
            solid_reg    <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_CENTER_X: center_x_reg <= cfg.data;
                REG_CENTER_Y: center_y_reg <= cfg.data;
                REG_CENTER_Z: center_z_reg <= cfg.data;
                REG_MAJOR:    major_reg    <= cfg.data[30:0];
                REG_MINOR:    minor_reg    <= cfg.data[30:0];
                REG_FALLOFF:  falloff_reg  <= cfg.data[30:0];
                REG_AIR:      air_reg      <= cfg.data;
                REG_SOLID:    solid_reg    <= cfg.data;
                default:      ;  // unknown index, ignored
            endcase
        end
    end

    // global advance: output register empty or being drained
    logic out_v_reg;
    logic ce;
    assign ce          = !out_v_reg || out_ch.ready;
    assign in_ch.ready = ce;

    // stage 0: offsets from center, magnitudes
    logic signed [32:0] dx, dy, dz;
    logic               v0_reg;
    logic [DIFF_W-1:0]  ax_reg, ay_reg, az_reg;
    logic               below0_reg, dig0_reg;

    assign dx = 33'(in_ch.pos_x) - 33'(center_x_reg);
    assign dy = 33'(in_ch.pos_y) - 33'(center_y_reg);
    assign dz = 33'(in_ch.pos_z) - 33'(center_z_reg);

    // stage 1: squares
    logic              v1_reg;
    logic [65:0]       sx_reg, sy_reg;
    logic [DIFF_W-1:0] az1_reg;
    logic              below1_reg, dig1_reg;

    // stage 2: radicand of the ring distance
    logic              v2_reg;
    logic [RAD_W-1:0]  rad1_reg;
    logic [DIFF_W-1:0] az2_reg;
    logic              below2_reg, dig2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (ce)
        begin
            v0_reg <= in_ch.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ax_reg     <= dx[32] ? DIFF_W'(-dx) : DIFF_W'(dx);
            ay_reg     <= dy[32] ? DIFF_W'(-dy) : DIFF_W'(dy);
            az_reg     <= dz[32] ? DIFF_W'(-dz) : DIFF_W'(dz);
            below0_reg <= in_ch.pos_z < in_ch.terrain_height;
            dig0_reg   <= in_ch.dig;

            sx_reg     <= 66'(ax_reg) * 66'(ax_reg);
            sy_reg     <= 66'(ay_reg) * 66'(ay_reg);
            az1_reg    <= az_reg;
            below1_reg <= below0_reg;
            dig1_reg   <= dig0_reg;

            rad1_reg   <= RAD_W'(sx_reg) + RAD_W'(sy_reg);
            az2_reg    <= az1_reg;
            below2_reg <= below1_reg;
            dig2_reg   <= dig1_reg;
        end
    end

    // ring distance r = floor(sqrt(dx^2 + dy^2))
    logic              r_v;
    logic [ROOT_W-1:0] r_root;
    logic [DIFF_W+1:0] r_side;

    tbsb_sqrt #(.RW(RAD_W), .QW(ROOT_W), .SW(DIFF_W + 2)) u_sqrt_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (ce),
        .in_valid  (v2_reg),
        .in_rad    (rad1_reg),
        .in_side   ({az2_reg, below2_reg, dig2_reg}),
        .out_valid (r_v),
        .out_root  (r_root),
        .out_side  (r_side)
    );

    // stage 3: offset from the ring, magnitude (r stays below 2^33)
    logic signed [ROOT_W:0] e;
    assign e = (ROOT_W+1)'(r_root) - (ROOT_W+1)'(major_reg);

    logic              v3_reg, v4_reg, v5_reg;
    logic [33:0]       ae_reg;
    logic [DIFF_W-1:0] az3_reg;
    logic              below3_reg, dig3_reg;
    logic [67:0]       se_reg;
    logic [65:0]       sz_reg;
    logic              below4_reg, dig4_reg;
    logic [RAD_W-1:0]  rad2_reg;
    logic              below5_reg, dig5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (ce)
        begin
            v3_reg <= r_v;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ae_reg     <= e[ROOT_W] ? 34'(-e) : 34'(e);
            az3_reg    <= r_side[DIFF_W+1:2];
            below3_reg <= r_side[1];
            dig3_reg   <= r_side[0];

            se_reg     <= 68'(ae_reg) * 68'(ae_reg);
            sz_reg     <= 66'(az3_reg) * 66'(az3_reg);
            below4_reg <= below3_reg;
            dig4_reg   <= dig3_reg;

            rad2_reg   <= RAD_W'(se_reg) + RAD_W'(sz_reg);
            below5_reg <= below4_reg;
            dig5_reg   <= dig4_reg;
        end
    end

    // tube distance s = floor(sqrt(e^2 + dz^2))
    logic              s_v;
    logic [ROOT_W-1:0] s_root;
    logic [1:0]        s_side;

    tbsb_sqrt #(.RW(RAD_W), .QW(ROOT_W), .SW(2)) u_sqrt_tube (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (ce),
        .in_valid  (v5_reg),
        .in_rad    (rad2_reg),
        .in_side   ({below5_reg, dig5_reg}),
        .out_valid (s_v),
        .out_root  (s_root),
        .out_side  (s_side)
    );

    // stage 6: signed distance and band classification
    logic signed [ROOT_W:0] d;
    logic                   d_out, d_in;
    assign d     = (ROOT_W+1)'(s_root) - (ROOT_W+1)'(minor_reg);
    assign d_out = d > $signed((ROOT_W+1)'(falloff_reg));
    assign d_in  = d <= 0;

    logic       v6_reg;
    logic [30:0] dnum_reg;
    blend_ctl_t ctl6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else if (ce)
        begin
            v6_reg <= s_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            // only band items divide; others push zero through
            dnum_reg       <= (d_out || d_in) ? 31'd0 : d[30:0];
            ctl6_reg.cls   <= d_out ? CLS_OUT : (d_in ? CLS_IN : CLS_BAND);
            ctl6_reg.below <= s_side[1];
            ctl6_reg.dig   <= s_side[0];
        end
    end

    // u = floor(d * 2^16 / falloff)
    logic               u_v;
    logic [DIV_Q_W-1:0] u;
    blend_ctl_t         u_ctl;

    tbsb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (ce),
        .in_valid  (v6_reg),
        .in_num    (dnum_reg),
        .divisor   (falloff_reg),
        .in_ctl    (ctl6_reg),
        .out_valid (u_v),
        .out_quo   (u),
        .out_ctl   (u_ctl)
    );

    // stages 7-8: smoothstep polynomial u^2 * (3 - 2u)
    logic        v7_reg, v8_reg, v9_reg, v10_reg;
    logic [33:0] uu_reg;
    logic [17:0] k_reg;
    blend_ctl_t  ctl7_reg, ctl8_reg;
    logic [51:0] p_reg;

    // stage 9: weight and end points
    logic [DIV_Q_W-1:0] w;
    logic [52:0]        p_rnd;
    assign p_rnd = 53'(p_reg) + (53'(1) << 31);
    assign w     = DIV_Q_W'(p_rnd >> 32);

    logic signed [31:0] a_next, b_next;
    logic [DIV_Q_W-1:0] w_next;

    always_comb
    begin
        a_next = '0;
        b_next = '0;
        w_next = '0;
        unique case (ctl8_reg.cls)
            CLS_OUT:
            begin
                a_next = '0;
            end
            CLS_IN:
            begin
                a_next = ctl8_reg.dig ? air_reg : solid_reg;
            end
            CLS_BAND:
            begin
                a_next = ctl8_reg.dig ? air_reg : solid_reg;
                b_next = (ctl8_reg.dig && ctl8_reg.below) ? solid_reg : 32'sd0;
                w_next = w;
            end
            default:
            begin
                a_next = '0;
            end
        endcase
    end

    logic signed [31:0]  a_reg, b_reg;
    logic [DIV_Q_W-1:0]  w_reg;
    logic signed [49:0]  pa_reg, pb_reg;

    // stage 11: rounded sum and saturation into the output register
    logic signed [50:0] x_sum;
    logic signed [34:0] x_shr;
    logic signed [31:0] sat;
    assign x_sum = 51'(pa_reg) + 51'(pb_reg) + 51'sd32768;
    assign x_shr = 35'(x_sum >>> FRAC_W);

    always_comb
    begin
        priority if (x_shr > 35'sd2147483647)
        begin
            sat = 32'sh7fffffff;
        end
        else if (x_shr < -35'sd2147483648)
        begin
            sat = 32'sh80000000;
        end
        else
        begin
            sat = 32'(x_shr);
        end
    end

    logic signed [31:0] out_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg    <= 1'b0;
            v8_reg    <= 1'b0;
            v9_reg    <= 1'b0;
            v10_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (ce)
        begin
            v7_reg    <= u_v;
            v8_reg    <= v7_reg;
            v9_reg    <= v8_reg;
            v10_reg   <= v9_reg;
            out_v_reg <= v10_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            uu_reg    <= 34'(u) * 34'(u);
            k_reg     <= 18'(3 * 65536) - 18'({u, 1'b0});
            ctl7_reg  <= u_ctl;

            p_reg     <= 52'(uu_reg) * 52'(k_reg);
            ctl8_reg  <= ctl7_reg;

            a_reg     <= a_next;
            b_reg     <= b_next;
            w_reg     <= w_next;

            pa_reg    <= 50'(a_reg) * $signed({1'b0, 17'(18'd65536 - 18'(w_reg))});
            pb_reg    <= 50'(b_reg) * $signed({1'b0, w_reg});

            out_d_reg <= sat;
        end
    end

    assign out_ch.valid     = out_v_reg;
    assign out_ch.sdf_value = out_d_reg;

    // pipeline holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ce |=> $stable(v6_reg) && $stable(v9_reg))
        else $error("pipeline moved during stall");

    // band ratio never exceeds one
    a_ratio: assert property (@(posedge clk) disable iff (!rst_n)
        (u_v && u_ctl.cls == CLS_BAND) |-> (u <= 17'h10000))
        else $error("blend ratio out of range");

    // items outside the band carry no blend weight
    a_weight: assert property (@(posedge clk) disable iff (!rst_n)
        (ce && v8_reg && ctl8_reg.cls != CLS_BAND) |=> (w_reg == '0))
        else $error("nonzero weight outside band");

    // a result leaves only when taken
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_ch.ready) |=> out_v_reg)
        else $error("result dropped");
endmodule
`default_nettype wire
